// ===== hdl/mmse_pkg.sv =====
// Shared types, constants and fixed-point helpers for the MMSE MIMO detector.
package mmse_pkg;

   localparam int WK_W    = 30;   // working values, 16 fraction bits
   localparam int WK_FRAC = 16;
   localparam int PROD_W  = 60;   // one real product of two working values
   localparam int ACC_W   = 64;   // exact sums of products
   localparam int DEN_W   = 60;   // squared pivot magnitude
   localparam int OUT_W   = 24;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;
   localparam int NV_W    = 16;

   localparam logic signed [ACC_W-1:0] WK_HI  = 64'sd536870911;
   localparam logic signed [ACC_W-1:0] WK_LO  = -64'sd536870912;
   localparam logic signed [ACC_W-1:0] OUT_HI = 64'sd8388607;
   localparam logic signed [ACC_W-1:0] OUT_LO = -64'sd8388608;

   localparam int GRAM_SHIFT  = 10;  // 26 to 16 fraction bits
   localparam int ELIM_SHIFT  = 16;  // 32 to 16 fraction bits
   localparam int FINAL_SHIFT = 19;  // 32 to 13 fraction bits
   localparam int NV_SHIFT    = 3;   // 13 to 16 fraction bits

   localparam logic [CSR_AW-3:0] REG_NOISE_VARIANCE = '0;

   // Kind of element carried by one load item
   localparam logic OP_CHANNEL  = 1'b0;
   localparam logic OP_RECEIVED = 1'b1;

   typedef struct packed {
      logic               op;
      logic [1:0]         rx_index;
      logic [1:0]         tx_index;
      logic signed [15:0] value_re;
      logic signed [15:0] value_im;
      logic               last;
   } req_item_type;

   typedef struct packed {
      logic [1:0]               stream_index;
      logic signed [OUT_W-1:0]  estimate_re;
      logic signed [OUT_W-1:0]  estimate_im;
      logic                     singular;
      logic                     last_result;
   } rsp_item_type;

   // Destination and sign of one product in the shared multiply-accumulate unit
   typedef struct packed {
      logic dst_im;
      logic neg;
   } mul_tag_type;

   typedef enum logic [5:0] {
      ST_IDLE,
      ST_G_RDA, ST_G_RDB, ST_G_CAPB, ST_G_MUL, ST_G_DRAIN, ST_G_WR1, ST_G_WR2,
      ST_P_RD, ST_P_CAP, ST_P_MUL, ST_P_DRAIN, ST_P_DEN,
      ST_N_RD, ST_N_CAP, ST_N_MUL, ST_N_DRAIN, ST_N_DRE, ST_N_WRE, ST_N_DIM, ST_N_WIM,
      ST_N_WR,
      ST_E_FRD, ST_E_FCAP, ST_E_RDB, ST_E_RDC, ST_E_MUL, ST_E_DRAIN, ST_E_WR,
      ST_F_RD, ST_F_CAP, ST_F_MUL, ST_F_DRAIN, ST_F_OUT
   } state_type;

   // Shift right by s, rounding half away from zero
   function automatic logic signed [ACC_W-1:0] rshr(input logic signed [ACC_W-1:0] x,
                                                    input int unsigned s);
      logic signed [ACC_W-1:0] half;
      logic signed [ACC_W-1:0] mag;
      half = 64'sd1 <<< (s - 1);
      mag  = -x;
      if (x >= 0) begin
         rshr = (x + half) >>> s;
      end else begin
         rshr = -((mag + half) >>> s);
      end
   endfunction

   // Saturate to the working range
   function automatic logic signed [WK_W-1:0] sat_wk(input logic signed [ACC_W-1:0] x);
      if (x > WK_HI) begin
         sat_wk = WK_HI[WK_W-1:0];
      end else if (x < WK_LO) begin
         sat_wk = WK_LO[WK_W-1:0];
      end else begin
         sat_wk = x[WK_W-1:0];
      end
   endfunction

   // Saturate to the output range
   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] x);
      if (x > OUT_HI) begin
         sat_out = OUT_HI[OUT_W-1:0];
      end else if (x < OUT_LO) begin
         sat_out = OUT_LO[OUT_W-1:0];
      end else begin
         sat_out = x[OUT_W-1:0];
      end
   endfunction

endpackage

// ===== hdl/mmse_mimo_detector_top.sv =====
// MMSE MIMO detector top level: load stores, sequencer, work memory and register port.
// A load item is taken while start is high and the detector is idle. The item flagged last
// holds busy for the detection; the shared divider runs 77 steps per quotient.
// Results leave one per strobe; the receiver cannot stall.
// Synchronous reset clears the sequencer, the strobe and noise_variance; stores are not cleared.
module mmse_mimo_detector_top import mmse_pkg::*; #(
   parameter int N_RX        = 4,
   parameter int N_TX        = 4,
   parameter int SAMPLE_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  req_item_type      req_item,
   output logic              busy,
   output logic              rsp_valid,
   output rsp_item_type      rsp_item,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   localparam int RW       = (N_RX > 1) ? $clog2(N_RX) : 1;
   localparam int TW       = (N_TX > 1) ? $clog2(N_TX) : 1;
   localparam int CH_DEPTH = N_RX * N_TX;
   localparam int CH_AW    = (CH_DEPTH > 1) ? $clog2(CH_DEPTH) : 1;
   localparam int WM_DEPTH = 2 * N_TX * N_TX;
   localparam int WM_AW    = $clog2(WM_DEPTH);
   localparam int SB       = SAMPLE_BITS;

   // Sign-extend a stored sample to the working width
   function automatic logic signed [WK_W-1:0] sx(input logic [SB-1:0] v);
      sx = WK_W'(signed'(v));
   endfunction

   function automatic logic [CH_AW-1:0] ch_addr(input logic [RW-1:0] row,
                                                input logic [TW-1:0] col);
      ch_addr = CH_AW'(int'(row) * N_TX + int'(col));
   endfunction

   function automatic logic [WM_AW-1:0] wm_addr(input logic k, input logic [TW-1:0] row,
                                                input logic [TW-1:0] col);
      wm_addr = WM_AW'(int'(k) * N_TX * N_TX + int'(row) * N_TX + int'(col));
   endfunction

   // Stores
   logic [2*SB-1:0]       ch_mem [CH_DEPTH];
   logic [2*SB-1:0]       ch_rd_ff;
   logic [2*SB-1:0]       rx_ff [N_RX];
   logic [2*WK_W-1:0]     wm_mem [WM_DEPTH];
   logic [2*WK_W-1:0]     wm_rd_ff;
   logic signed [WK_W-1:0] z_re_ff [N_TX];
   logic signed [WK_W-1:0] z_im_ff [N_TX];
   logic [NV_W-1:0]       noise_ff;

   // Sequencer state and counters
   state_type             state_ff, state_in;
   logic [TW-1:0]         i_ff, i_in;
   logic [TW-1:0]         j_ff, j_in;
   logic [RW-1:0]         gr_ff, gr_in;
   logic [TW-1:0]         er_ff, er_in;
   logic                  k_ff, k_in;
   logic [1:0]            ph_ff, ph_in;
   logic                  match_ff, match_in;
   logic                  sing_ff, sing_in;
   logic [DEN_W-1:0]      den_ff, den_in;

   // Operand and scalar registers
   logic signed [WK_W-1:0] opa_re_ff, opa_re_in, opa_im_ff, opa_im_in;
   logic signed [WK_W-1:0] opb_re_ff, opb_re_in, opb_im_ff, opb_im_in;
   logic signed [WK_W-1:0] piv_re_ff, piv_re_in, piv_im_ff, piv_im_in;
   logic signed [WK_W-1:0] fac_re_ff, fac_re_in, fac_im_ff, fac_im_in;
   logic signed [WK_W-1:0] c_re_ff, c_re_in, c_im_ff, c_im_in;
   logic signed [WK_W-1:0] q_re_ff, q_re_in, q_im_ff, q_im_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_item_type           rsp_item_ff, rsp_item_in;

   // Control toward the memories and shared units
   logic [CH_AW-1:0]       ch_raddr;
   logic [WM_AW-1:0]       wm_raddr;
   logic                   wm_we;
   logic [WM_AW-1:0]       wm_waddr;
   logic [2*WK_W-1:0]      wm_wdata;
   logic                   mul_valid;
   logic signed [WK_W-1:0] mul_a, mul_b;
   mul_tag_type            mul_tag;
   logic                   conj;
   logic                   acc_clr;
   logic                   div_start;
   logic signed [ACC_W-1:0] div_num;
   logic                   div_done;
   logic signed [WK_W-1:0] quot;
   logic signed [ACC_W-1:0] acc_re, acc_im;

   // Loop conditions
   logic                   i_last, j_last, gr_last, ph_last, den_zero;
   logic [TW:0]            first_row, next_row;
   logic                   first_ok, next_ok;

   // Values written back
   logic signed [WK_W-1:0] gb_re, g_re, g_im, e_re, e_im;
   logic signed [WK_W-1:0] id_re;

   // Load path
   logic                   accept;
   logic                   rx_ok, tx_ok;
   logic [23:0]            in_re_z, in_im_z;
   logic [2*SB-1:0]        in_word;
   logic                   csr_wr;

   assign accept  = start && (state_ff == ST_IDLE);
   assign busy    = (state_ff != ST_IDLE);
   assign rx_ok   = int'(req_item.rx_index) < N_RX;
   assign tx_ok   = int'(req_item.tx_index) < N_TX;
   assign in_re_z = 24'($unsigned(req_item.value_re));
   assign in_im_z = 24'($unsigned(req_item.value_im));
   assign in_word = {in_re_z[SB-1:0], in_im_z[SB-1:0]};

   // Register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[CSR_AW-1:2] == REG_NOISE_VARIANCE);
   assign prdata = (paddr[CSR_AW-1:2] == REG_NOISE_VARIANCE) ? CSR_DW'(noise_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_ff <= '0;
      end else if (csr_wr) begin
         noise_ff <= pwdata[NV_W-1:0];
      end
   end

   // Store load items
   always_ff @(posedge clock) begin
      if (accept && req_item.op == OP_CHANNEL && rx_ok && tx_ok) begin
         ch_mem[ch_addr(RW'(req_item.rx_index), TW'(req_item.tx_index))] <= in_word;
      end
      if (accept && req_item.op == OP_RECEIVED && rx_ok) begin
         rx_ff[RW'(req_item.rx_index)] <= in_word;
      end
      ch_rd_ff <= ch_mem[ch_raddr];
   end

   // Work memory
   always_ff @(posedge clock) begin
      if (wm_we) begin
         wm_mem[wm_waddr] <= wm_wdata;
      end
      wm_rd_ff <= wm_mem[wm_raddr];
   end

   // Loop conditions
   always_comb begin
      i_last    = (i_ff == TW'(N_TX - 1));
      j_last    = (j_ff == TW'(N_TX - 1));
      gr_last   = (gr_ff == RW'(N_RX - 1));
      ph_last   = (ph_ff == 2'd3);
      den_zero  = (den_ff == '0);
      first_row = (i_ff == '0) ? (TW+1)'(1) : '0;
      first_ok  = int'(first_row) < N_TX;
      next_row  = (TW+1)'(er_ff) + (TW+1)'(1);
      if (next_row == (TW+1)'(i_ff)) begin
         next_row = next_row + (TW+1)'(1);
      end
      next_ok   = int'(next_row) < N_TX;
   end

   // Write-back values
   always_comb begin
      gb_re = sat_wk(rshr(acc_re, GRAM_SHIFT));
      g_im  = sat_wk(rshr(acc_im, GRAM_SHIFT));
      if (!match_ff && i_ff == j_ff) begin
         g_re = sat_wk(ACC_W'(gb_re) + (ACC_W'(noise_ff) <<< NV_SHIFT));
      end else begin
         g_re = gb_re;
      end
      id_re = (i_ff == j_ff) ? WK_W'(1 << WK_FRAC) : '0;
      e_re  = sat_wk(ACC_W'(c_re_ff) - rshr(acc_re, ELIM_SHIFT));
      e_im  = sat_wk(ACC_W'(c_im_ff) - rshr(acc_im, ELIM_SHIFT));
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (accept && req_item.last) state_in = ST_G_RDA;
         ST_G_RDA:   state_in = ST_G_RDB;
         ST_G_RDB:   state_in = ST_G_CAPB;
         ST_G_CAPB:  state_in = ST_G_MUL;
         ST_G_MUL:   if (ph_last) state_in = gr_last ? ST_G_DRAIN : ST_G_RDA;
         ST_G_DRAIN: state_in = ST_G_WR1;
         ST_G_WR1: begin
            if (!match_ff) begin
               state_in = ST_G_WR2;
            end else begin
               state_in = i_last ? ST_P_RD : ST_G_RDA;
            end
         end
         ST_G_WR2:   state_in = ST_G_RDA;
         ST_P_RD:    state_in = ST_P_CAP;
         ST_P_CAP:   state_in = ST_P_MUL;
         ST_P_MUL:   if (ph_last) state_in = ST_P_DRAIN;
         ST_P_DRAIN: state_in = ST_P_DEN;
         ST_P_DEN:   state_in = ST_N_RD;
         ST_N_RD:    state_in = ST_N_CAP;
         ST_N_CAP:   state_in = ST_N_MUL;
         ST_N_MUL:   if (ph_last) state_in = ST_N_DRAIN;
         ST_N_DRAIN: state_in = den_zero ? ST_N_WR : ST_N_DRE;
         ST_N_DRE:   state_in = ST_N_WRE;
         ST_N_WRE:   if (div_done) state_in = ST_N_DIM;
         ST_N_DIM:   state_in = ST_N_WIM;
         ST_N_WIM:   if (div_done) state_in = ST_N_WR;
         ST_N_WR: begin
            if (!(k_ff && j_last)) begin
               state_in = ST_N_RD;
            end else if (first_ok) begin
               state_in = ST_E_FRD;
            end else begin
               state_in = i_last ? ST_F_RD : ST_P_RD;
            end
         end
         ST_E_FRD:   state_in = ST_E_FCAP;
         ST_E_FCAP:  state_in = ST_E_RDB;
         ST_E_RDB:   state_in = ST_E_RDC;
         ST_E_RDC:   state_in = ST_E_MUL;
         ST_E_MUL:   if (ph_last) state_in = ST_E_DRAIN;
         ST_E_DRAIN: state_in = ST_E_WR;
         ST_E_WR: begin
            if (!(k_ff && j_last)) begin
               state_in = ST_E_RDB;
            end else if (next_ok) begin
               state_in = ST_E_FRD;
            end else begin
               state_in = i_last ? ST_F_RD : ST_P_RD;
            end
         end
         ST_F_RD:    state_in = ST_F_CAP;
         ST_F_CAP:   state_in = ST_F_MUL;
         ST_F_MUL:   if (ph_last) state_in = j_last ? ST_F_DRAIN : ST_F_RD;
         ST_F_DRAIN: state_in = ST_F_OUT;
         ST_F_OUT:   state_in = i_last ? ST_IDLE : ST_F_RD;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      ch_raddr  = ch_addr(gr_ff, i_ff);
      wm_raddr  = wm_addr(k_ff, i_ff, j_ff);
      wm_we     = 1'b0;
      wm_waddr  = wm_addr(k_ff, i_ff, j_ff);
      wm_wdata  = {g_re, g_im};
      mul_valid = 1'b0;
      conj      = 1'b0;
      acc_clr   = 1'b0;
      div_start = 1'b0;
      div_num   = acc_re;
      case (state_ff)
         ST_IDLE:   acc_clr = 1'b1;
         ST_G_RDA:  ch_raddr = ch_addr(gr_ff, i_ff);
         ST_G_RDB:  ch_raddr = ch_addr(gr_ff, j_ff);
         ST_G_MUL: begin
            mul_valid = 1'b1;
            conj      = 1'b1;
         end
         ST_G_WR1: begin
            wm_we   = !match_ff;
            acc_clr = match_ff;
         end
         ST_G_WR2: begin
            wm_we    = 1'b1;
            wm_waddr = wm_addr(1'b1, i_ff, j_ff);
            wm_wdata = {id_re, WK_W'(0)};
            acc_clr  = 1'b1;
         end
         ST_P_RD: begin
            wm_raddr = wm_addr(1'b0, i_ff, i_ff);
            acc_clr  = 1'b1;
         end
         ST_P_MUL: begin
            mul_valid = 1'b1;
            conj      = 1'b1;
         end
         ST_N_RD: acc_clr = 1'b1;
         ST_N_MUL: begin
            mul_valid = 1'b1;
            conj      = 1'b1;
         end
         ST_N_DRE: div_start = 1'b1;
         ST_N_DIM: begin
            div_start = 1'b1;
            div_num   = acc_im;
         end
         ST_N_WR: begin
            wm_we    = 1'b1;
            wm_wdata = den_zero ? '0 : {q_re_ff, q_im_ff};
         end
         ST_E_FRD:  wm_raddr = wm_addr(1'b0, er_ff, i_ff);
         ST_E_RDB:  wm_raddr = wm_addr(k_ff, i_ff, j_ff);
         ST_E_RDC: begin
            wm_raddr = wm_addr(k_ff, er_ff, j_ff);
            acc_clr  = 1'b1;
         end
         ST_E_MUL:  mul_valid = 1'b1;
         ST_E_WR: begin
            wm_we    = 1'b1;
            wm_waddr = wm_addr(k_ff, er_ff, j_ff);
            wm_wdata = {e_re, e_im};
         end
         ST_F_RD: begin
            wm_raddr = wm_addr(1'b1, i_ff, j_ff);
            acc_clr  = (j_ff == '0);
         end
         ST_F_MUL:  mul_valid = 1'b1;
         default: begin
         end
      endcase
      // Pick the real or imaginary parts for this phase of the complex product
      mul_a          = ph_ff[0] ? opa_im_ff : opa_re_ff;
      mul_b          = (ph_ff == 2'd1 || ph_ff == 2'd2) ? opb_im_ff : opb_re_ff;
      mul_tag.dst_im = ph_ff[1];
      mul_tag.neg    = (ph_ff == 2'd1) ? !conj : ((ph_ff == 2'd3) ? conj : 1'b0);
   end

   // Counters and datapath registers
   always_comb begin
      i_in      = i_ff;
      j_in      = j_ff;
      gr_in     = gr_ff;
      er_in     = er_ff;
      k_in      = k_ff;
      ph_in     = ph_ff;
      match_in  = match_ff;
      sing_in   = sing_ff;
      den_in    = den_ff;
      opa_re_in = opa_re_ff;
      opa_im_in = opa_im_ff;
      opb_re_in = opb_re_ff;
      opb_im_in = opb_im_ff;
      piv_re_in = piv_re_ff;
      piv_im_in = piv_im_ff;
      fac_re_in = fac_re_ff;
      fac_im_in = fac_im_ff;
      c_re_in   = c_re_ff;
      c_im_in   = c_im_ff;
      q_re_in   = q_re_ff;
      q_im_in   = q_im_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      case (state_ff)
         ST_IDLE: begin
            i_in     = '0;
            j_in     = '0;
            gr_in    = '0;
            k_in     = 1'b0;
            ph_in    = '0;
            match_in = 1'b0;
            sing_in  = 1'b0;
         end
         ST_G_RDB: begin
            opa_re_in = sx(ch_rd_ff[2*SB-1:SB]);
            opa_im_in = sx(ch_rd_ff[SB-1:0]);
         end
         ST_G_CAPB: begin
            if (match_ff) begin
               opb_re_in = sx(rx_ff[gr_ff][2*SB-1:SB]);
               opb_im_in = sx(rx_ff[gr_ff][SB-1:0]);
            end else begin
               opb_re_in = sx(ch_rd_ff[2*SB-1:SB]);
               opb_im_in = sx(ch_rd_ff[SB-1:0]);
            end
         end
         ST_G_MUL: begin
            ph_in = ph_ff + 2'd1;
            if (ph_last && !gr_last) gr_in = gr_ff + RW'(1);
         end
         ST_G_WR1: begin
            gr_in = '0;
            if (match_ff) begin
               match_in = 1'b0;
               j_in     = '0;
               i_in     = i_last ? '0 : i_ff + TW'(1);
            end
         end
         ST_G_WR2: begin
            if (j_last) begin
               match_in = 1'b1;
            end else begin
               j_in = j_ff + TW'(1);
            end
         end
         ST_P_CAP: begin
            piv_re_in = wm_rd_ff[2*WK_W-1:WK_W];
            piv_im_in = wm_rd_ff[WK_W-1:0];
            opa_re_in = wm_rd_ff[2*WK_W-1:WK_W];
            opa_im_in = wm_rd_ff[WK_W-1:0];
            opb_re_in = wm_rd_ff[2*WK_W-1:WK_W];
            opb_im_in = wm_rd_ff[WK_W-1:0];
         end
         ST_P_MUL:  ph_in = ph_ff + 2'd1;
         ST_P_DEN: begin
            den_in = acc_re[DEN_W-1:0];
            if (acc_re == '0) sing_in = 1'b1;
            k_in = 1'b0;
            j_in = '0;
         end
         ST_N_CAP: begin
            opa_re_in = piv_re_ff;
            opa_im_in = piv_im_ff;
            opb_re_in = wm_rd_ff[2*WK_W-1:WK_W];
            opb_im_in = wm_rd_ff[WK_W-1:0];
         end
         ST_N_MUL:  ph_in = ph_ff + 2'd1;
         ST_N_WRE:  if (div_done) q_re_in = quot;
         ST_N_WIM:  if (div_done) q_im_in = quot;
         ST_N_WR: begin
            if (!(k_ff && j_last)) begin
               if (j_last) begin
                  j_in = '0;
                  k_in = 1'b1;
               end else begin
                  j_in = j_ff + TW'(1);
               end
            end else begin
               er_in = first_row[TW-1:0];
               if (!first_ok) i_in = i_last ? '0 : i_ff + TW'(1);
            end
         end
         ST_E_FCAP: begin
            fac_re_in = wm_rd_ff[2*WK_W-1:WK_W];
            fac_im_in = wm_rd_ff[WK_W-1:0];
            k_in = 1'b0;
            j_in = '0;
         end
         ST_E_RDC: begin
            opa_re_in = fac_re_ff;
            opa_im_in = fac_im_ff;
            opb_re_in = wm_rd_ff[2*WK_W-1:WK_W];
            opb_im_in = wm_rd_ff[WK_W-1:0];
         end
         ST_E_MUL: begin
            ph_in = ph_ff + 2'd1;
            if (ph_ff == 2'd0) begin
               c_re_in = wm_rd_ff[2*WK_W-1:WK_W];
               c_im_in = wm_rd_ff[WK_W-1:0];
            end
         end
         ST_E_WR: begin
            if (!(k_ff && j_last)) begin
               if (j_last) begin
                  j_in = '0;
                  k_in = 1'b1;
               end else begin
                  j_in = j_ff + TW'(1);
               end
            end else if (next_ok) begin
               er_in = next_row[TW-1:0];
            end else begin
               i_in = i_last ? '0 : i_ff + TW'(1);
               j_in = '0;
            end
         end
         ST_F_CAP: begin
            opa_re_in = wm_rd_ff[2*WK_W-1:WK_W];
            opa_im_in = wm_rd_ff[WK_W-1:0];
            opb_re_in = z_re_ff[j_ff];
            opb_im_in = z_im_ff[j_ff];
         end
         ST_F_MUL: begin
            ph_in = ph_ff + 2'd1;
            if (ph_last && !j_last) j_in = j_ff + TW'(1);
         end
         ST_F_OUT: begin
            rsp_valid_in             = 1'b1;
            rsp_item_in.stream_index = 2'(i_ff);
            rsp_item_in.estimate_re  = sat_out(rshr(acc_re, FINAL_SHIFT));
            rsp_item_in.estimate_im  = sat_out(rshr(acc_im, FINAL_SHIFT));
            rsp_item_in.singular     = sing_ff;
            rsp_item_in.last_result  = i_last;
            i_in = i_ff + TW'(1);
            j_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         gr_ff        <= '0;
         er_ff        <= '0;
         k_ff         <= 1'b0;
         ph_ff        <= '0;
         match_ff     <= 1'b0;
         sing_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         gr_ff        <= gr_in;
         er_ff        <= er_in;
         k_ff         <= k_in;
         ph_ff        <= ph_in;
         match_ff     <= match_in;
         sing_ff      <= sing_in;
      end
      den_ff      <= den_in;
      opa_re_ff   <= opa_re_in;
      opa_im_ff   <= opa_im_in;
      opb_re_ff   <= opb_re_in;
      opb_im_ff   <= opb_im_in;
      piv_re_ff   <= piv_re_in;
      piv_im_ff   <= piv_im_in;
      fac_re_ff   <= fac_re_in;
      fac_im_ff   <= fac_im_in;
      c_re_ff     <= c_re_in;
      c_im_ff     <= c_im_in;
      q_re_ff     <= q_re_in;
      q_im_ff     <= q_im_in;
      rsp_item_ff <= rsp_item_in;
   end

   // Hold the matched-filter vector
   always_ff @(posedge clock) begin
      if (state_ff == ST_G_WR1 && match_ff) begin
         z_re_ff[i_ff] <= g_re;
         z_im_ff[i_ff] <= g_im;
      end
   end

   mmse_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .mul_valid (mul_valid),
      .mul_a     (mul_a),
      .mul_b     (mul_b),
      .mul_tag   (mul_tag),
      .acc_clr   (acc_clr),
      .acc_re    (acc_re),
      .acc_im    (acc_im)
   );

   mmse_div u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .num       (div_num),
      .den       (den_ff),
      .div_done  (div_done),
      .quot      (quot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== hdl/mmse_mac.sv =====
// Shared real multiplier with registered product and complex accumulator.
module mmse_mac import mmse_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    mul_valid,
   input  logic signed [WK_W-1:0]  mul_a,
   input  logic signed [WK_W-1:0]  mul_b,
   input  mul_tag_type             mul_tag,
   input  logic                    acc_clr,
   output logic signed [ACC_W-1:0] acc_re,
   output logic signed [ACC_W-1:0] acc_im
);

   logic                     prod_valid_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   mul_tag_type              prod_tag_ff;
   logic signed [ACC_W-1:0]  acc_re_ff, acc_re_in;
   logic signed [ACC_W-1:0]  acc_im_ff, acc_im_in;
   logic signed [ACC_W-1:0]  term;

   // Form one product
   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Add or subtract the registered product into its accumulator
   always_comb begin
      term      = prod_tag_ff.neg ? -ACC_W'(prod_ff) : ACC_W'(prod_ff);
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      if (acc_clr) begin
         acc_re_in = '0;
         acc_im_in = '0;
      end else if (prod_valid_ff) begin
         if (prod_tag_ff.dst_im) begin
            acc_im_in = acc_im_ff + term;
         end else begin
            acc_re_in = acc_re_ff + term;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= mul_valid;
      end
      prod_ff     <= prod_in;
      prod_tag_ff <= mul_tag;
      acc_re_ff   <= acc_re_in;
      acc_im_ff   <= acc_im_in;
   end

   assign acc_re = acc_re_ff;
   assign acc_im = acc_im_ff;

endmodule

// ===== hdl/mmse_div.sv =====
// Radix-2 restoring divider: |num| / den with 16 fraction bits, clamped, sign applied.
module mmse_div import mmse_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    div_start,
   input  logic signed [ACC_W-1:0] num,
   input  logic [DEN_W-1:0]        den,
   output logic                    div_done,
   output logic signed [WK_W-1:0]  quot
);

   localparam int MAG_W       = DEN_W + 1;
   localparam int REM_W       = DEN_W + 2;
   localparam int INT_STEPS   = MAG_W;
   localparam int FRAC_STEPS  = 16;
   localparam int TOTAL_STEPS = INT_STEPS + FRAC_STEPS;
   localparam int CNT_W       = $clog2(TOTAL_STEPS);
   localparam logic [MAG_W-1:0] Q_CLAMP = MAG_W'(1) << 13;

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [MAG_W-1:0]   mag_ff;
   logic [REM_W-1:0]   rem_ff;
   logic [MAG_W-1:0]   q_ff;
   logic [DEN_W-1:0]   den_ff;
   logic               neg_ff;
   logic signed [ACC_W-1:0] abs_num;
   logic [REM_W-1:0]   rem_sh;
   logic [REM_W-1:0]   rem_in;
   logic [MAG_W-1:0]   q_in;
   logic               qbit;
   logic               int_phase;
   logic signed [ACC_W-1:0] q_signed;

   assign abs_num   = (num < 0) ? -num : num;
   assign int_phase = (int'(cnt_ff) < INT_STEPS);

   // One quotient bit per cycle
   always_comb begin
      if (int_phase) begin
         rem_sh = {rem_ff[REM_W-2:0], mag_ff[MAG_W-1]};
      end else begin
         rem_sh = {rem_ff[REM_W-2:0], 1'b0};
      end
      qbit   = (rem_sh >= REM_W'(den_ff));
      rem_in = qbit ? (rem_sh - REM_W'(den_ff)) : rem_sh;
      q_in   = {q_ff[MAG_W-2:0], qbit};
      // Clamp the integer part once it is complete
      if (int'(cnt_ff) == INT_STEPS - 1 && q_in > Q_CLAMP) begin
         q_in = Q_CLAMP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (int'(cnt_ff) == TOTAL_STEPS - 1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (div_start) begin
         mag_ff <= abs_num[MAG_W-1:0];
         rem_ff <= '0;
         q_ff   <= '0;
         den_ff <= den;
         neg_ff <= (num < 0);
      end else if (busy_ff) begin
         mag_ff <= {mag_ff[MAG_W-2:0], 1'b0};
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

   // Apply the sign and saturate
   assign q_signed = neg_ff ? -ACC_W'(q_ff) : ACC_W'(q_ff);
   assign quot     = sat_wk(q_signed);
   assign div_done = done_ff;

endmodule
